// ===== hw/rtl/swc_pkg.sv =====
// Shared constants and types of the sliding window covariance block.
package swc_pkg;

  // Window geometry.
  localparam int WINDOW_MAX = 256;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = 9;
  localparam int SAMPLE_W   = 16;
  localparam int PAIR_W     = 2 * SAMPLE_W;

  // Window sums and their derived products.
  localparam int SUM_W  = 24;
  localparam int SQ_W   = 39;
  localparam int XY_W   = 40;
  localparam int PRD_W  = 48;
  localparam int PXY_W  = 50;
  localparam int S2_W   = 47;
  localparam int DEN_W  = 16;

  // Back end arithmetic.
  localparam int DIV_W  = S2_W + 8;
  localparam int MUL_W  = 2 * S2_W;
  localparam int ROOT_W = 126;
  localparam int QB_W   = 16;
  localparam int CORR_SHIFT = 30;
  localparam int LANES    = 3;
  localparam int CNT_BITS = $clog2(DIV_W);

  // Result fields.
  localparam int VAR_W = 39;
  localparam int COV_W = 40;
  localparam int COR_W = 16;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified item, ready for the back end.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [S2_W-1:0]  sxx;
    logic [S2_W-1:0]  syy;
    logic [S2_W-1:0]  cabs;
    logic             cneg;
    logic [DEN_W-1:0] d;
  } job_t;

  // Queue status seen by its two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hw/rtl/sliding_window_covariance.sv =====
// The back end runs its 55-step divisions, 47-step shift-add products and
// 16-step correlation search one after another.
// The front end takes the next pair while the back end works, through a two-entry queue.
// Reset is synchronous: window length 256, window empty, queue empty, no result pending.
// The pair store is not cleared; only pairs written since the last emptying are read.
module sliding_window_covariance (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [swc_pkg::SAMPLE_W-1:0] x_sample,
  input  logic signed [swc_pkg::SAMPLE_W-1:0] y_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swc_pkg::CNT_W-1:0]     pair_count,
  output logic [swc_pkg::VAR_W-1:0]     variance_of_x,
  output logic [swc_pkg::VAR_W-1:0]     variance_of_y,
  output logic signed [swc_pkg::COV_W-1:0] covariance_xy,
  output logic signed [swc_pkg::COR_W-1:0] correlation_xy,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swc_pkg::CNT_W-1:0]     cfg_data
);
  import swc_pkg::*;

  job_t          push_job, head_job;
  logic          push, pop;
  queue_status_t q_status;

  // Front end: window store and sums.
  swc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_sample  (x_sample),
    .y_sample  (y_sample),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .job       (push_job)
  );

  // Queue of classified transactions.
  swc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (push_job),
    .pop    (pop),
    .head   (head_job),
    .status (q_status)
  );

  // Back end: statistics and output register.
  swc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head_job),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pair_count     (pair_count),
    .variance_of_x  (variance_of_x),
    .variance_of_y  (variance_of_y),
    .covariance_xy  (covariance_xy),
    .correlation_xy (correlation_xy)
  );

endmodule

// ===== hw/rtl/swc_front.sv =====
// Front end: accepts sample pairs, keeps the window store and the exact window sums.
module swc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [swc_pkg::SAMPLE_W-1:0] x_sample,
  input  logic signed [swc_pkg::SAMPLE_W-1:0] y_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swc_pkg::CNT_W-1:0]     cfg_data,
  input  swc_pkg::queue_status_t        q_status,
  output logic                          push,
  output swc_pkg::job_t                 job
);
  import swc_pkg::*;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_READ = 6'b000010,
    F_SUM  = 6'b000100,
    F_MUL  = 6'b001000,
    F_PUSH = 6'b010000,
    F_WAIT = 6'b100000
  } front_state_t;

  front_state_t state;

  logic [PAIR_W-1:0] mem [WINDOW_MAX];
  logic [PAIR_W-1:0] rdata;

  logic [CNT_W-1:0] window_length;
  logic [PTR_W-1:0] oldest_pointer;
  logic [CNT_W-1:0] held_count;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [SQ_W-1:0] sum_xx, sum_yy;
  logic signed [XY_W-1:0] sum_xy;

  logic signed [SAMPLE_W-1:0] x_reg, y_reg, ox, oy;
  logic signed [PAIR_W-1:0] xx, yy, xy, oxx, oyy, oxy;
  logic full;

  logic [PRD_W-1:0] p_nxx, p_nyy;
  logic signed [PRD_W-1:0] p_sx2, p_sy2, p_sxy;
  logic signed [PXY_W-1:0] p_nxy;
  logic [DEN_W-1:0] den;

  logic accept, cfg_write;
  logic [CNT_W-1:0] cfg_clamped;
  logic [PRD_W-1:0] sxx_full, syy_full;
  logic signed [PXY_W-1:0] cxy;
  logic [PXY_W-1:0] cxy_mag;
  logic [PTR_W-1:0] wr_addr;

  // Handshakes: configuration takes precedence in the idle state.
  assign cfg_ready = (state == F_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = (state != F_IDLE) || cfg_valid;
  assign accept    = in_valid && !in_stall;

  // Register value out of range is clamped to the legal window.
  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_data > CNT_W'(WINDOW_MAX)) begin
      cfg_clamped = CNT_W'(WINDOW_MAX);
    end
  end

  // Store address of the new pair; the same whether or not the oldest leaves.
  assign wr_addr = oldest_pointer + held_count[PTR_W-1:0];

  // Pair store, read at the oldest entry and written with the new pair.
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[oldest_pointer];
    end
    if (state == F_SUM) begin
      mem[wr_addr] <= {x_reg, y_reg};
    end
  end

  // Derived statistics numerators.
  assign sxx_full = p_nxx - PRD_W'(p_sx2);
  assign syy_full = p_nyy - PRD_W'(p_sy2);
  assign cxy      = p_nxy - PXY_W'(p_sxy);
  assign cxy_mag  = cxy[PXY_W-1] ? PXY_W'(-cxy) : PXY_W'(cxy);

  assign push = (state == F_PUSH) && !q_status.full;
  always_comb begin
    job.n    = held_count;
    job.sxx  = sxx_full[S2_W-1:0];
    job.syy  = syy_full[S2_W-1:0];
    job.cabs = cxy_mag[S2_W-1:0];
    job.cneg = cxy[PXY_W-1];
    job.d    = den;
  end

  // Control sequence and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= F_IDLE;
      window_length  <= CNT_W'(WINDOW_MAX);
      oldest_pointer <= '0;
      held_count     <= '0;
      sum_x          <= '0;
      sum_y          <= '0;
      sum_xx         <= '0;
      sum_yy         <= '0;
      sum_xy         <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (cfg_write) begin
            window_length  <= cfg_clamped;
            oldest_pointer <= '0;
            held_count     <= '0;
            sum_x          <= '0;
            sum_y          <= '0;
            sum_xx         <= '0;
            sum_yy         <= '0;
            sum_xy         <= '0;
          end else if (accept) begin
            state <= F_READ;
          end
        end
        F_READ: begin
          state <= F_SUM;
        end
        F_SUM: begin
          sum_x  <= sum_x - SUM_W'(ox) + SUM_W'(x_reg);
          sum_y  <= sum_y - SUM_W'(oy) + SUM_W'(y_reg);
          sum_xx <= sum_xx - SQ_W'(unsigned'(oxx)) + SQ_W'(unsigned'(xx));
          sum_yy <= sum_yy - SQ_W'(unsigned'(oyy)) + SQ_W'(unsigned'(yy));
          sum_xy <= sum_xy - XY_W'(oxy) + XY_W'(xy);
          if (full) begin
            oldest_pointer <= oldest_pointer + PTR_W'(1);
          end else begin
            held_count <= held_count + CNT_W'(1);
          end
          state <= F_MUL;
        end
        F_MUL: begin
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_status.full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg <= x_sample;
      y_reg <= y_sample;
      full  <= (held_count >= window_length);
    end
    // Squares and cross products of the new and the leaving pair.
    if (state == F_READ) begin
      xx <= PAIR_W'(x_reg) * PAIR_W'(x_reg);
      yy <= PAIR_W'(y_reg) * PAIR_W'(y_reg);
      xy <= PAIR_W'(x_reg) * PAIR_W'(y_reg);
      if (full) begin
        ox  <= rdata[PAIR_W-1:SAMPLE_W];
        oy  <= rdata[SAMPLE_W-1:0];
        oxx <= PAIR_W'($signed(rdata[PAIR_W-1:SAMPLE_W]))
             * PAIR_W'($signed(rdata[PAIR_W-1:SAMPLE_W]));
        oyy <= PAIR_W'($signed(rdata[SAMPLE_W-1:0]))
             * PAIR_W'($signed(rdata[SAMPLE_W-1:0]));
        oxy <= PAIR_W'($signed(rdata[PAIR_W-1:SAMPLE_W]))
             * PAIR_W'($signed(rdata[SAMPLE_W-1:0]));
      end else begin
        ox  <= '0;
        oy  <= '0;
        oxx <= '0;
        oyy <= '0;
        oxy <= '0;
      end
    end
    // Products of the updated sums.
    if (state == F_MUL) begin
      p_nxx <= PRD_W'(held_count) * PRD_W'(sum_xx);
      p_nyy <= PRD_W'(held_count) * PRD_W'(sum_yy);
      p_sx2 <= PRD_W'(sum_x) * PRD_W'(sum_x);
      p_sy2 <= PRD_W'(sum_y) * PRD_W'(sum_y);
      p_sxy <= PRD_W'(sum_x) * PRD_W'(sum_y);
      p_nxy <= PXY_W'($signed({1'b0, held_count})) * PXY_W'(sum_xy);
      den   <= DEN_W'(held_count) * DEN_W'(held_count - CNT_W'(1));
    end
  end

endmodule

// ===== hw/rtl/swc_queue.sv =====
// Short queue of classified items between the front end and the back end.
module swc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  swc_pkg::job_t          job_in,
  input  logic                   pop,
  output swc_pkg::job_t          head,
  output swc_pkg::queue_status_t status
);
  import swc_pkg::*;

  job_t slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;

  assign status.full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign head         = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/swc_back.sv =====
// Back end: iterative divisions, products and correlation search, with the output register.
module swc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  swc_pkg::job_t                 head,
  input  swc_pkg::queue_status_t        q_status,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swc_pkg::CNT_W-1:0]     pair_count,
  output logic [swc_pkg::VAR_W-1:0]     variance_of_x,
  output logic [swc_pkg::VAR_W-1:0]     variance_of_y,
  output logic signed [swc_pkg::COV_W-1:0] covariance_xy,
  output logic signed [swc_pkg::COR_W-1:0] correlation_xy
);
  import swc_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_DIV  = 5'b00010,
    B_MUL  = 5'b00100,
    B_ROOT = 5'b01000,
    B_DONE = 5'b10000
  } back_state_t;

  back_state_t state;
  logic [CNT_BITS-1:0] cnt;
  job_t job;

  logic [DIV_W-1:0] num [LANES];
  logic [DEN_W-1:0] rem [LANES];
  logic [DIV_W-1:0] num_next [LANES];
  logic [DEN_W-1:0] rem_next [LANES];

  logic [MUL_W-1:0] mc1, mc2, acc1, acc2;
  logic [S2_W-1:0]  mp1, mp2;

  logic [ROOT_W-1:0] q2, tq, pk, r30, trial;
  logic [QB_W-1:0]   qv;
  logic              fits;

  logic [VAR_W-1:0] varx_sat, vary_sat;
  logic [COV_W-1:0] cov_val;
  logic [COR_W-1:0] corr_val;
  logic [DIV_W-1:0] m;
  logic             stats_on, corr_on, out_free;

  assign pop      = (state == B_IDLE) && !q_status.empty;
  assign out_free = !out_valid || !out_stall;

  // Restoring division step, one quotient bit per lane each cycle.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [DEN_W:0] tr;
      tr = {rem[i], num[i][DIV_W-1]};
      if (tr >= {1'b0, job.d}) begin
        rem_next[i] = DEN_W'(tr - {1'b0, job.d});
        num_next[i] = {num[i][DIV_W-2:0], 1'b1};
      end else begin
        rem_next[i] = tr[DEN_W-1:0];
        num_next[i] = {num[i][DIV_W-2:0], 1'b0};
      end
    end
  end

  // Correlation search step: trial square of q with the current bit set.
  assign trial = q2 + tq + pk;
  assign fits  = (trial <= r30);

  // Result shaping with saturation.
  assign m = num[2];
  always_comb begin
    varx_sat = (|num[0][DIV_W-1:VAR_W]) ? '1 : num[0][VAR_W-1:0];
    vary_sat = (|num[1][DIV_W-1:VAR_W]) ? '1 : num[1][VAR_W-1:0];
    if (job.cneg) begin
      if ((|m[DIV_W-1:COV_W]) || (m[COV_W-1] && (|m[COV_W-2:0]))) begin
        cov_val = {1'b1, {(COV_W-1){1'b0}}};
      end else begin
        cov_val = COV_W'(-m[COV_W-1:0]);
      end
    end else begin
      if (|m[DIV_W-1:COV_W-1]) begin
        cov_val = {1'b0, {(COV_W-1){1'b1}}};
      end else begin
        cov_val = m[COV_W-1:0];
      end
    end
    if (job.cneg) begin
      corr_val = COR_W'(-qv);
    end else if (qv[QB_W-1]) begin
      corr_val = {1'b0, {(COR_W-1){1'b1}}};
    end else begin
      corr_val = qv;
    end
  end

  assign stats_on = (job.n >= CNT_W'(2));
  assign corr_on  = stats_on && (job.sxx != '0) && (job.syy != '0);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result clears the output, unless a new one replaces it.
      if (out_valid && !out_stall && (state != B_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            cnt   <= CNT_BITS'(DIV_W - 1);
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (cnt == '0) begin
            cnt   <= CNT_BITS'(S2_W - 1);
            state <= B_MUL;
          end else begin
            cnt <= cnt - CNT_BITS'(1);
          end
        end
        B_MUL: begin
          if (cnt == '0) begin
            cnt   <= CNT_BITS'(QB_W - 1);
            state <= B_ROOT;
          end else begin
            cnt <= cnt - CNT_BITS'(1);
          end
        end
        B_ROOT: begin
          if (cnt == '0) begin
            state <= B_DONE;
          end else begin
            cnt <= cnt - CNT_BITS'(1);
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Arithmetic datapath.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop) begin
          job    <= head;
          num[0] <= {head.sxx, 8'b0};
          num[1] <= {head.syy, 8'b0};
          num[2] <= {head.cabs, 8'b0};
          for (int i = 0; i < LANES; i++) begin
            rem[i] <= '0;
          end
          mc1  <= MUL_W'(head.sxx);
          mp1  <= head.syy;
          mc2  <= MUL_W'(head.cabs);
          mp2  <= head.cabs;
          acc1 <= '0;
          acc2 <= '0;
        end
      end
      B_DIV: begin
        for (int i = 0; i < LANES; i++) begin
          num[i] <= num_next[i];
          rem[i] <= rem_next[i];
        end
      end
      B_MUL: begin
        // Shift and add products Sxx*Syy and C*C.
        if (mp1[0]) begin
          acc1 <= acc1 + mc1;
        end
        if (mp2[0]) begin
          acc2 <= acc2 + mc2;
        end
        mc1 <= mc1 << 1;
        mc2 <= mc2 << 1;
        mp1 <= mp1 >> 1;
        mp2 <= mp2 >> 1;
        if (cnt == '0) begin
          q2 <= '0;
          tq <= '0;
          qv <= '0;
          pk <= ROOT_W'(acc1 + (mp1[0] ? mc1 : '0)) << (2 * (QB_W - 1));
          r30 <= ROOT_W'(acc2 + (mp2[0] ? mc2 : '0)) << CORR_SHIFT;
        end
      end
      B_ROOT: begin
        // Bit by bit search for the largest q with q*q*Sxx*Syy <= C*C*2^30.
        if (fits) begin
          q2 <= trial;
          tq <= (tq >> 1) + pk;
          qv[cnt[$clog2(QB_W)-1:0]] <= 1'b1;
        end else begin
          tq <= tq >> 1;
        end
        pk <= pk >> 2;
      end
      B_DONE: begin
        if (out_free) begin
          pair_count     <= job.n;
          variance_of_x  <= stats_on ? varx_sat : '0;
          variance_of_y  <= stats_on ? vary_sat : '0;
          covariance_xy  <= stats_on ? cov_val : '0;
          correlation_xy <= corr_on ? corr_val : '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sliding window covariance block.
`timescale 1ns / 100ps

module tb_top;
  import swc_pkg::*;

  // One set of window statistics, as the block reports it.
  typedef struct {
    logic [CNT_W-1:0] n;
    logic [VAR_W-1:0] vx;
    logic [VAR_W-1:0] vy;
    logic [COV_W-1:0] cov;
    logic [COR_W-1:0] cor;
  } window_stats_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 3000;
  localparam int EXP_DEPTH      = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] x_sample = '0;
  logic signed [SAMPLE_W-1:0] y_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CNT_W-1:0] pair_count;
  logic [VAR_W-1:0] variance_of_x;
  logic [VAR_W-1:0] variance_of_y;
  logic signed [COV_W-1:0] covariance_xy;
  logic signed [COR_W-1:0] correlation_xy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  // Model of the window held by the block.
  int unsigned win_len = 256;
  logic signed [SAMPLE_W-1:0] store_x [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] store_y [WINDOW_MAX];
  int unsigned oldest = 0;
  int unsigned held = 0;
  longint sx = 0, sy = 0, sxx = 0, syy = 0, sxy = 0;

  // Expected results in order, as a ring with write and read counts.
  window_stats_t exp_ring [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  sliding_window_covariance u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_sample(x_sample), .y_sample(y_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .pair_count(pair_count), .variance_of_x(variance_of_x),
    .variance_of_y(variance_of_y), .covariance_xy(covariance_xy),
    .correlation_xy(correlation_xy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Empty the model window, as reset and a length write do.
  function automatic void clear_window();
    oldest = 0;
    held = 0;
    sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
  endfunction

  // Largest q in 0..32768 with q*q*Sxx*Syy <= C*C*2^30.
  function automatic int unsigned corr_search(logic [63:0] cabs, logic [63:0] vx,
                                              logic [63:0] vy);
    logic [191:0] rhs, lhs;
    int unsigned lo, hi, mid;
    rhs = (192'(cabs) * 192'(cabs)) << CORR_SHIFT;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = 192'(mid * mid) * 192'(vx) * 192'(vy);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Slide one pair into the window and compute the statistics it yields.
  function automatic window_stats_t slide_and_measure(logic signed [SAMPLE_W-1:0] x,
                                                      logic signed [SAMPLE_W-1:0] y);
    window_stats_t r;
    longint xi, yi, ox, oy, n, dx, dy, cxy;
    logic [63:0] ux, uy, cabs, d;
    logic [127:0] q;
    int unsigned mag;
    xi = longint'(x);
    yi = longint'(y);
    if (held >= win_len && held > 0) begin
      ox = longint'(store_x[oldest]);
      oy = longint'(store_y[oldest]);
      sx -= ox; sy -= oy;
      sxx -= ox * ox; syy -= oy * oy; sxy -= ox * oy;
      oldest = (oldest + 1) % WINDOW_MAX;
      held--;
    end
    store_x[(oldest + held) % WINDOW_MAX] = x;
    store_y[(oldest + held) % WINDOW_MAX] = y;
    held++;
    sx += xi; sy += yi;
    sxx += xi * xi; syy += yi * yi; sxy += xi * yi;
    r.n = held[CNT_W-1:0];
    r.vx = '0; r.vy = '0; r.cov = '0; r.cor = '0;
    n = longint'(held);
    if (n >= 2) begin
      dx = n * sxx - sx * sx;
      dy = n * syy - sy * sy;
      cxy = n * sxy - sx * sy;
      ux = dx;
      uy = dy;
      cabs = (cxy < 0) ? -cxy : cxy;
      d = n * (n - 1);
      q = (128'(ux) << 8) / 128'(d);
      r.vx = (q > {VAR_W{1'b1}}) ? {VAR_W{1'b1}} : q[VAR_W-1:0];
      q = (128'(uy) << 8) / 128'(d);
      r.vy = (q > {VAR_W{1'b1}}) ? {VAR_W{1'b1}} : q[VAR_W-1:0];
      q = (128'(cabs) << 8) / 128'(d);
      r.cov = (cxy < 0) ? -q[COV_W-1:0] : q[COV_W-1:0];
      if (ux != 0 && uy != 0) begin
        mag = corr_search(cabs, ux, uy);
        if (cxy < 0) r.cor = -mag[COR_W-1:0];
        else r.cor = (mag > 32767) ? 16'sd32767 : mag[COR_W-1:0];
      end
    end
    return r;
  endfunction

  // Offer one pair, with a random gap first, and wait for the transaction.
  task automatic send_pair(logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_sample <= x;
    y_sample <= y;
    do @(posedge clk); while (in_stall);
    exp_ring[exp_wr % EXP_DEPTH] = slide_and_measure(x, y);
    exp_wr++;
  endtask

  // Wait for every result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    wait (exp_rd == exp_wr);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the window length once the block is idle.
  task automatic write_window_length(logic [CNT_W-1:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (len < 1) win_len = 1;
    else if (len > WINDOW_MAX) win_len = WINDOW_MAX;
    else win_len = 32'(len);
    clear_window();
  endtask

  // Random pair of one of several shapes: wide, extreme, correlated, opposed, flat.
  task automatic send_random_pair();
    logic signed [SAMPLE_W-1:0] x, y;
    logic signed [SAMPLE_W-1:0] corners [5] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1,
                                               16'sd32767};
    x = SAMPLE_W'($urandom);
    y = SAMPLE_W'($urandom);
    case ($urandom_range(5))
      1: begin
        x = corners[$urandom_range(4)];
        y = corners[$urandom_range(4)];
      end
      2: y = x + 16'($signed($urandom_range(64)) - 32);
      3: y = ~x;
      4: x = 16'sd1234;
      default: ;
    endcase
    send_pair(x, y);
  endtask

  task automatic run_random(int count);
    repeat (count) send_random_pair();
  endtask

  // Directed: extremes, single pair, flat data, full-scale correlation, length clamps.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_pair(16'sd32767, -16'sd32768);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(16'sd0, 16'sd0);
    send_pair(-16'sd1, 16'sd1);
    write_window_length(9'd0);
    send_pair(16'sd5, 16'sd7);
    send_pair(-16'sd5, 16'sd9);
    write_window_length(9'd4);
    send_pair(16'sd10, 16'sd3);
    send_pair(16'sd10, -16'sd8);
    send_pair(16'sd10, 16'sd100);
    write_window_length(9'd8);
    send_pair(16'sd1, 16'sd1);
    send_pair(16'sd2, 16'sd2);
    send_pair(16'sd300, 16'sd300);
    write_window_length(9'd8);
    send_pair(16'sd1, -16'sd1);
    send_pair(16'sd2, -16'sd2);
    send_pair(-16'sd300, 16'sd300);
    write_window_length(9'd511);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd32767, -16'sd32768);
  endtask

  // Full 256-pair window wrapping round, no idling on either side.
  task automatic test_long_window();
    write_window_length(9'd256);
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(300);
  endtask

  task automatic test_sender_gaps();
    write_window_length(9'($urandom_range(40, 4)));
    send_idle_pct = 58;
    stall_pct = 0;
    run_random(160);
  endtask

  task automatic test_receiver_stalls();
    write_window_length(9'd1);
    send_idle_pct = 0;
    stall_pct = 58;
    run_random(100);
  endtask

  task automatic test_both_idle();
    write_window_length(9'd2);
    send_idle_pct = 35;
    stall_pct = 35;
    run_random(100);
  endtask

  // Long receiver hold-off while pairs keep coming, so the input backs up.
  task automatic test_backpressure();
    write_window_length(9'($urandom_range(255, 41)));
    send_idle_pct = 35;
    stall_pct = 35;
    hold_req = 1'b1;
    run_random(290);
  endtask

  // Receiver stall: random, or held for a long stretch on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    window_stats_t e;
    if (!rst && out_valid && !out_stall) begin
      if (exp_rd == exp_wr) begin
        $error("result with no pair outstanding");
        errors++;
      end else begin
        e = exp_ring[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (pair_count !== e.n) begin
          $error("pair_count exp %0d act %0d", e.n, pair_count);
          errors++;
        end
        if (variance_of_x !== e.vx) begin
          $error("variance_of_x exp %0d act %0d", e.vx, variance_of_x);
          errors++;
        end
        if (variance_of_y !== e.vy) begin
          $error("variance_of_y exp %0d act %0d", e.vy, variance_of_y);
          errors++;
        end
        if (covariance_xy !== e.cov) begin
          $error("covariance_xy exp %0d act %0d", $signed(e.cov), covariance_xy);
          errors++;
        end
        if (correlation_xy !== e.cor) begin
          $error("correlation_xy exp %0d act %0d", $signed(e.cor), correlation_xy);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_window();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
